FILE: sv/wbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// White blob steering tracker package
// Field widths, drive command constants and the divider step count.
// ----------------------------------------------------------------------------
package wbst_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COL_W   = 12;
    localparam int unsigned FW_W    = 13;
    localparam int unsigned LIN_W   = 12;
    localparam int unsigned ANG_W   = 16;
    // w - min - max stays within [-8190, 8191]
    localparam int unsigned NUM_W   = 15;
    // quotient bits when |num| < w (Q2.14 fraction)
    localparam int unsigned QUO_W   = 14;
    localparam int unsigned CNT_W   = 4;

    typedef logic [CHAN_W-1:0]        chan_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic [FW_W-1:0]          fw_t;
    typedef logic [LIN_W-1:0]         lin_t;
    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic [QUO_W-1:0]         quo_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam chan_t WHITE_LEVEL = 8'd255;
    localparam lin_t  LIN_FOUND   = 12'd3277;
    localparam lin_t  LIN_SEARCH  = 12'd1638;
    localparam lin_t  LIN_STOP    = 12'd0;
    localparam ang_t  ANG_ONE     = 16'sd16384;
    localparam ang_t  ANG_ZERO    = 16'sd0;
    localparam cnt_t  DIV_LAST    = 4'd13;
    localparam fw_t   WIDTH_RESET = 13'd640;

endpackage
`default_nettype wire

FILE: sv/white_blob_steering_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// White blob steering tracker
// Tracks the white pixel column span of each frame and issues a drive
// command on the frame's last pixel when the command changes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per transaction (colour channels, column index and
//   a frame_end flag). m_* carries a drive command (linear speed, Q2.14
//   angular rate), given only when it differs from the last command sent.
//   cfg_* writes frame_width; it is always ready and is meant to be written
//   while no frame_end pixel is in progress.
//   An ordinary pixel leaves the block idle: s_ready stays high, so pixels
//   stream at one per cycle.
//   A frame_end pixel with white seen goes through capture, range check,
//   14 restoring divide steps through one shared subtract/compare and command
//   hand-off; the divide steps are skipped when |w - min - max| is at or past
//   the width and the turn saturates. Without white it goes from capture
//   straight to hand-off, where the command is loaded onto m_*.
//   The command sits in an output register; pixels keep flowing while it
//   waits. If the receiver stalls and a new command is ready, the block
//   holds in the hand-off step with s_ready low until m_ready frees the
//   register.
//   Reset (aresetn low, synchronous) clears the tracking, the last command
//   (0, 0) and sets frame_width to 640 (MAX_WIDTH if smaller).
// ----------------------------------------------------------------------------
module white_blob_steering_tracker_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    // configuration
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [wbst_pkg::FW_W-1:0]   cfg_data,
    // pixel input
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [wbst_pkg::CHAN_W-1:0] s_red,
    input  wire  [wbst_pkg::CHAN_W-1:0] s_green,
    input  wire  [wbst_pkg::CHAN_W-1:0] s_blue,
    input  wire  [wbst_pkg::COL_W-1:0]  s_column,
    input  wire                         s_frame_end,
    // command output
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [wbst_pkg::LIN_W-1:0]  m_linear_speed,
    output logic signed [wbst_pkg::ANG_W-1:0] m_angular_rate
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    localparam logic [31:0] MAX_W32   = 32'(MAX_WIDTH);
    localparam logic [31:0] RESET_W32 = (32'(wbst_pkg::WIDTH_RESET) > MAX_W32) ?
                                        MAX_W32 : 32'(wbst_pkg::WIDTH_RESET);

    logic [1:0]          state_reg, state_next;
    wbst_pkg::fw_t       width_reg, width_next;
    wbst_pkg::col_t      min_reg, min_next;
    wbst_pkg::col_t      max_reg, max_next;
    logic                seen_frame_reg, seen_frame_next;
    logic                seen_ever_reg, seen_ever_next;
    wbst_pkg::lin_t      last_lin_reg, last_lin_next;
    wbst_pkg::ang_t      last_ang_reg, last_ang_next;
    wbst_pkg::lin_t      cmd_lin_reg, cmd_lin_next;
    wbst_pkg::ang_t      cmd_ang_reg, cmd_ang_next;
    wbst_pkg::num_t      num_reg, num_next;
    logic [wbst_pkg::FW_W-1:0] rem_reg, rem_next;
    wbst_pkg::quo_t      quo_reg, quo_next;
    wbst_pkg::cnt_t      cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    wbst_pkg::lin_t      m_lin_reg, m_lin_next;
    wbst_pkg::ang_t      m_ang_reg, m_ang_next;

    logic                in_fire;
    logic                is_white;
    wbst_pkg::col_t      pix_min, pix_max;
    wbst_pkg::num_t      num_abs;
    logic [wbst_pkg::FW_W:0]   rem_dbl;
    logic [wbst_pkg::FW_W+1:0] div_diff;
    wbst_pkg::quo_t      quo_step;
    wbst_pkg::ang_t      quo_mag;
    wbst_pkg::fw_t       cfg_width;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign in_fire        = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_linear_speed = m_lin_reg;
    assign m_angular_rate = m_ang_reg;

    assign is_white = (s_red == wbst_pkg::WHITE_LEVEL) && (s_green == wbst_pkg::WHITE_LEVEL)
                      && (s_blue == wbst_pkg::WHITE_LEVEL);

    // column span including the current pixel
    always_comb begin
        pix_min = min_reg;
        pix_max = max_reg;
        if (is_white) begin
            if (!seen_frame_reg) begin
                pix_min = s_column;
                pix_max = s_column;
            end else begin
                if (s_column < min_reg) pix_min = s_column;
                if (s_column > max_reg) pix_max = s_column;
            end
        end
    end

    // width clamp to [1, MAX_WIDTH]
    always_comb begin
        cfg_width = cfg_data;
        if (cfg_data == '0) begin
            cfg_width = wbst_pkg::FW_W'(1);
        end else if (32'(cfg_data) > MAX_W32) begin
            cfg_width = MAX_W32[wbst_pkg::FW_W-1:0];
        end
    end

    // shared divide step: shift remainder, trial subtract
    assign num_abs  = num_reg[wbst_pkg::NUM_W-1] ? -num_reg : num_reg;
    assign rem_dbl  = {rem_reg, 1'b0};
    assign div_diff = {1'b0, rem_dbl} - {2'b00, width_reg};
    assign quo_step = {quo_reg[wbst_pkg::QUO_W-2:0], ~div_diff[wbst_pkg::FW_W+1]};
    assign quo_mag  = wbst_pkg::ang_t'({2'b00, quo_step});

    always_comb begin
        state_next      = state_reg;
        width_next      = width_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        seen_frame_next = seen_frame_reg;
        seen_ever_next  = seen_ever_reg;
        last_lin_next   = last_lin_reg;
        last_ang_next   = last_ang_reg;
        cmd_lin_next    = cmd_lin_reg;
        cmd_ang_next    = cmd_ang_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_lin_next      = m_lin_reg;
        m_ang_next      = m_ang_reg;

        if (cfg_valid && cfg_ready) begin
            width_next = cfg_width;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!s_frame_end) begin
                        min_next        = pix_min;
                        max_next        = pix_max;
                        seen_frame_next = seen_frame_reg || is_white;
                    end else begin
                        min_next        = '0;
                        max_next        = '0;
                        seen_frame_next = 1'b0;
                        num_next        = wbst_pkg::num_t'({2'b00, width_reg})
                                          - wbst_pkg::num_t'({3'b000, pix_min})
                                          - wbst_pkg::num_t'({3'b000, pix_max});
                        if (seen_frame_reg || is_white) begin
                            seen_ever_next = 1'b1;
                            cmd_lin_next   = wbst_pkg::LIN_FOUND;
                            state_next     = ST_PREP;
                        end else if (!seen_ever_reg) begin
                            cmd_lin_next = wbst_pkg::LIN_SEARCH;
                            cmd_ang_next = wbst_pkg::ANG_ONE;
                            state_next   = ST_PUSH;
                        end else begin
                            cmd_lin_next = wbst_pkg::LIN_STOP;
                            cmd_ang_next = wbst_pkg::ANG_ZERO;
                            state_next   = ST_PUSH;
                        end
                    end
                end
            end
            ST_PREP: begin
                // an offset |w - min - max| at or past the width saturates to full turn
                if ({2'b00, width_reg} <= num_abs) begin
                    cmd_ang_next = num_reg[wbst_pkg::NUM_W-1] ? -wbst_pkg::ANG_ONE
                                                                : wbst_pkg::ANG_ONE;
                    state_next   = ST_PUSH;
                end else begin
                    rem_next   = num_abs[wbst_pkg::FW_W-1:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_diff[wbst_pkg::FW_W+1]) begin
                    rem_next = div_diff[wbst_pkg::FW_W-1:0];
                end else begin
                    rem_next = rem_dbl[wbst_pkg::FW_W-1:0];
                end
                quo_next = quo_step;
                cnt_next = cnt_reg + wbst_pkg::cnt_t'(1);
                if (cnt_reg == wbst_pkg::DIV_LAST) begin
                    // truncation toward zero: divide magnitude, then restore sign
                    cmd_ang_next = num_reg[wbst_pkg::NUM_W-1] ? -quo_mag : quo_mag;
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if ((cmd_lin_reg == last_lin_reg) && (cmd_ang_reg == last_ang_reg)) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_lin_next    = cmd_lin_reg;
                    m_ang_next    = cmd_ang_reg;
                    last_lin_next = cmd_lin_reg;
                    last_ang_next = cmd_ang_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            width_reg      <= RESET_W32[wbst_pkg::FW_W-1:0];
            min_reg        <= '0;
            max_reg        <= '0;
            seen_frame_reg <= 1'b0;
            seen_ever_reg  <= 1'b0;
            last_lin_reg   <= '0;
            last_ang_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            seen_frame_reg <= seen_frame_next;
            seen_ever_reg  <= seen_ever_next;
            last_lin_reg   <= last_lin_next;
            last_ang_reg   <= last_ang_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_lin_reg <= cmd_lin_next;
        cmd_ang_reg <= cmd_ang_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        m_lin_reg   <= m_lin_next;
        m_ang_reg   <= m_ang_next;
    end

`ifndef SYNTHESIS
    // the command on the output is always the one recorded as last sent
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_linear_speed == last_lin_reg && m_angular_rate == last_ang_reg))
        else $error("output command differs from recorded last command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_linear_speed == wbst_pkg::LIN_STOP
                     || m_linear_speed == wbst_pkg::LIN_SEARCH
                     || m_linear_speed == wbst_pkg::LIN_FOUND))
        else $error("linear speed outside the three command levels");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angular_rate <= wbst_pkg::ANG_ONE
                     && m_angular_rate >= -wbst_pkg::ANG_ONE))
        else $error("angular rate beyond saturation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= wbst_pkg::DIV_LAST))
        else $error("divide step count overran");

    assert property (@(posedge aclk) disable iff (!aresetn)
        seen_ever_reg |=> seen_ever_reg)
        else $error("seen-ever flag cleared outside reset");
`endif

endmodule
`default_nettype wire

FILE: test/white_blob_steering_tracker_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White blob steering tracker checker
// Follows the width register and the accepted pixels, works out each drive
// command the block should send and compares it with every command taken
// from m_*.
// ----------------------------------------------------------------------------
module white_blob_steering_tracker_unit_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    input  wire                               cfg_ready,
    input  wire  [wbst_pkg::FW_W-1:0]         cfg_data,
    input  wire                               s_valid,
    input  wire                               s_ready,
    input  wire  [wbst_pkg::CHAN_W-1:0]       s_red,
    input  wire  [wbst_pkg::CHAN_W-1:0]       s_green,
    input  wire  [wbst_pkg::CHAN_W-1:0]       s_blue,
    input  wire  [wbst_pkg::COL_W-1:0]        s_column,
    input  wire                               s_frame_end,
    input  wire                               m_valid,
    input  wire                               m_ready,
    input  wire  [wbst_pkg::LIN_W-1:0]        m_linear_speed,
    input  wire  signed [wbst_pkg::ANG_W-1:0] m_angular_rate,
    output int unsigned                       n_errors,
    output int unsigned                       n_pending
);

    typedef struct packed {
        wbst_pkg::lin_t lin;
        wbst_pkg::ang_t ang;
    } drive_cmd_t;

    drive_cmd_t     cmd_q[$];
    drive_cmd_t     last_cmd;
    drive_cmd_t     want;
    wbst_pkg::fw_t  width_reg;
    wbst_pkg::col_t span_lo;
    wbst_pkg::col_t span_hi;
    logic           white_now;
    logic           white_ever;
    int unsigned    fault_cnt = 0;

    task automatic report_fault(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        fault_cnt++;
    endtask

    // span tracking per pixel, command on the frame's last pixel
    task automatic track_pixel(input wbst_pkg::chan_t r, input wbst_pkg::chan_t g,
                               input wbst_pkg::chan_t b, input wbst_pkg::col_t col,
                               input logic fe);
        drive_cmd_t cmd;
        longint     w;
        longint     q;
        if (r == wbst_pkg::WHITE_LEVEL && g == wbst_pkg::WHITE_LEVEL
            && b == wbst_pkg::WHITE_LEVEL) begin
            if (!white_now || col < span_lo) span_lo = col;
            if (!white_now || col > span_hi) span_hi = col;
            white_now = 1'b1;
        end
        if (fe) begin
            if (white_now) begin
                white_ever = 1'b1;
                w = longint'(width_reg);
                if (w < 1) w = 1;
                if (w > MAX_WIDTH) w = MAX_WIDTH;
                // signed divide truncates toward zero, then clamp to +-1.0
                q = ((w - longint'(span_lo) - longint'(span_hi))
                     * longint'(wbst_pkg::ANG_ONE)) / w;
                if (q > longint'(wbst_pkg::ANG_ONE)) q = longint'(wbst_pkg::ANG_ONE);
                if (q < -longint'(wbst_pkg::ANG_ONE)) q = -longint'(wbst_pkg::ANG_ONE);
                cmd.lin = wbst_pkg::LIN_FOUND;
                cmd.ang = wbst_pkg::ang_t'(q);
            end else if (!white_ever) begin
                cmd.lin = wbst_pkg::LIN_SEARCH;
                cmd.ang = wbst_pkg::ANG_ONE;
            end else begin
                cmd.lin = wbst_pkg::LIN_STOP;
                cmd.ang = wbst_pkg::ANG_ZERO;
            end
            if (cmd.lin != last_cmd.lin || cmd.ang != last_cmd.ang) begin
                cmd_q.push_back(cmd);
                last_cmd = cmd;
            end
            white_now = 1'b0;
            span_lo   = '0;
            span_hi   = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    = wbst_pkg::WIDTH_RESET;
            span_lo      = '0;
            span_hi      = '0;
            white_now    = 1'b0;
            white_ever   = 1'b0;
            last_cmd.lin = wbst_pkg::LIN_STOP;
            last_cmd.ang = wbst_pkg::ANG_ZERO;
            cmd_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) width_reg = cfg_data;
            // a command never comes from a pixel taken at the same edge
            if (m_valid && m_ready) begin
                if (cmd_q.size() == 0) begin
                    report_fault($sformatf("command lin %0d ang %0d with none outstanding",
                                           m_linear_speed, m_angular_rate));
                end else begin
                    want = cmd_q.pop_front();
                    if (m_linear_speed !== want.lin)
                        report_fault($sformatf("linear_speed %0d, wanted %0d",
                                               m_linear_speed, want.lin));
                    if (m_angular_rate !== want.ang)
                        report_fault($sformatf("angular_rate %0d, wanted %0d",
                                               m_angular_rate, $signed(want.ang)));
                end
            end
            if (s_valid && s_ready)
                track_pixel(s_red, s_green, s_blue, s_column, s_frame_end);
        end
        n_errors  <= fault_cnt;
        n_pending <= cmd_q.size();
    end

endmodule

FILE: test/white_blob_steering_tracker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White blob steering tracker testbench
// Streams directed and random frames of pixels through the block over a range
// of frame widths, with bursty input and a stalling receiver; the checker
// beside the block predicts and compares every drive command.
// ----------------------------------------------------------------------------
module white_blob_steering_tracker_unit_test;

    localparam int WIDTH_MAX = 4096;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            cfg_valid   = 1'b0;
    logic            cfg_ready;
    wbst_pkg::fw_t   cfg_data    = '0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    wbst_pkg::chan_t s_red       = '0;
    wbst_pkg::chan_t s_green     = '0;
    wbst_pkg::chan_t s_blue      = '0;
    wbst_pkg::col_t  s_column    = '0;
    logic            s_frame_end = 1'b0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    wbst_pkg::lin_t  m_linear_speed;
    wbst_pkg::ang_t  m_angular_rate;
    int unsigned     n_errors;
    int unsigned     n_pending;

    rx_mode_t        rx_mode     = RX_OPEN;
    int unsigned     rx_left     = 0;
    int unsigned     stall_left  = 0;
    int unsigned     burst_left  = 0;
    wbst_pkg::fw_t   fw_now      = wbst_pkg::WIDTH_RESET;

    always #4 aclk = ~aclk;

    white_blob_steering_tracker_unit #(
        .MAX_WIDTH (WIDTH_MAX)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_column       (s_column),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_linear_speed (m_linear_speed),
        .m_angular_rate (m_angular_rate)
    );

    white_blob_steering_tracker_unit_checker #(
        .MAX_WIDTH (WIDTH_MAX)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_column       (s_column),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_linear_speed (m_linear_speed),
        .m_angular_rate (m_angular_rate),
        .n_errors       (n_errors),
        .n_pending      (n_pending)
    );

    // receiver: open, coin-toss and long-stall stretches, chosen at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_left <= $urandom_range(40, 300);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (stall_left != 0) begin
                        m_ready    <= 1'b0;
                        stall_left <= stall_left - 1;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(4, 25);
                    end
                end
            endcase
        end
    end

    initial begin
        #5_000_000;
        $display("white_blob_steering_tracker_unit: mismatch");
        $finish;
    end

    // one pixel transaction, then maybe a gap between bursts
    task automatic send_pixel(input wbst_pkg::chan_t r, input wbst_pkg::chan_t g,
                              input wbst_pkg::chan_t b, input wbst_pkg::col_t col,
                              input logic fe);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_red       <= r;
        s_green     <= g;
        s_blue      <= b;
        s_column    <= col;
        s_frame_end <= fe;
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_width(input wbst_pkg::fw_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fw_now = value;
    endtask

    // drain every outstanding command, then let a silent divide finish
    task automatic settle();
        int unsigned spin;
        s_valid <= 1'b0;
        spin = 0;
        @(posedge aclk);
        while (n_pending != 0 && spin < 4000) begin
            @(posedge aclk);
            spin++;
        end
        repeat (40) @(posedge aclk);
    endtask

    task automatic stream_frames(input int unsigned n_pix);
        int unsigned     sent;
        int unsigned     len;
        int unsigned     i;
        int unsigned     eff_w;
        int unsigned     k;
        logic            dark;
        wbst_pkg::chan_t r;
        wbst_pkg::chan_t g;
        wbst_pkg::chan_t b;
        wbst_pkg::col_t  col;
        eff_w = (fw_now == '0) ? 1
                : ((32'(fw_now) > WIDTH_MAX) ? WIDTH_MAX : 32'(fw_now));
        sent  = 0;
        while (sent < n_pix) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            // some frames carry no white at all
            dark = ($urandom_range(0, 5) == 0);
            for (i = 0; i < len; i++) begin
                r = wbst_pkg::chan_t'($urandom_range(0, 255));
                g = wbst_pkg::chan_t'($urandom_range(0, 255));
                b = wbst_pkg::chan_t'($urandom_range(0, 255));
                k = $urandom_range(0, 9);
                if (k < 3 && !dark) begin
                    {r, g, b} = {3{wbst_pkg::WHITE_LEVEL}};
                end else if (k == 3) begin
                    // near white: one channel short of full
                    {r, g, b} = {3{wbst_pkg::WHITE_LEVEL}};
                    case ($urandom_range(0, 2))
                        0: r = wbst_pkg::chan_t'($urandom_range(0, 254));
                        1: g = wbst_pkg::chan_t'($urandom_range(0, 254));
                        default: b = wbst_pkg::chan_t'($urandom_range(0, 254));
                    endcase
                end
                col = ($urandom_range(0, 4) != 0)
                      ? wbst_pkg::col_t'($urandom_range(0, eff_w - 1))
                      : wbst_pkg::col_t'($urandom_range(0, 4095));
                send_pixel(r, g, b, col, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        wbst_pkg::fw_t phase_widths[8];
        int unsigned   ph;
        phase_widths = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd2, 13'd0, 13'd640};
        phase_widths[6] = wbst_pkg::fw_t'($urandom_range(3, 4095));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames at the reset width of 640
        send_pixel(8'd0, 8'd0, 8'd0, 12'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 1'b1);
        send_pixel(8'd254, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, 12'd4095, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, 8'd254, wbst_pkg::WHITE_LEVEL, 12'd0, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, 8'd254, 12'd4095, 1'b1);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd0, 1'b1);
        // span past the width saturates the turn
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd4095, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 12'd0, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd4095, 1'b1);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd500, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 12'd300, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd100, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 12'd639, 1'b1);
        // same span again: command unchanged
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd100, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd500, 1'b1);
        // blob lost after being seen, then lost again
        send_pixel(8'd0, 8'd0, 8'd0, 12'd10, 1'b1);
        send_pixel(8'd128, 8'd64, 8'd32, 12'd2000, 1'b1);
        // quotients that truncate toward zero on both sides
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd319, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd320, 1'b1);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd321, 1'b0);
        send_pixel(wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL, wbst_pkg::WHITE_LEVEL,
                   12'd320, 1'b1);
        settle();

        for (ph = 0; ph < 8; ph++) begin
            write_width(phase_widths[ph]);
            stream_frames(215);
            settle();
        end

        if (n_errors == 0 && n_pending == 0) begin
            $display("white_blob_steering_tracker_unit: match");
        end else begin
            $display("white_blob_steering_tracker_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: white_blob_steering_tracker_unit.f
sv/wbst_pkg.sv
sv/white_blob_steering_tracker_unit.sv
test/white_blob_steering_tracker_unit_checker.sv
test/white_blob_steering_tracker_unit_test.sv
